@@ design/assert_macros.svh @@
// Assertion macros for the unescaper RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define JSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ design/jsu_pkg.sv @@
// Package for the JSON string unescaper: phase and status codes, the
// result-run type, hex digit decode and UTF-8 encoding. No dependencies.
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_ESCAPE,
        PH_HEX_FIRST,
        PH_WANT_BSLASH,
        PH_WANT_U,
        PH_HEX_LOW
    } phase_t;

    typedef enum logic [3:0] {
        ST_BYTE           = 4'd0,
        ST_END            = 4'd1,
        ST_UNTERMINATED   = 4'd2,
        ST_ESCAPE_CUT     = 4'd3,
        ST_UNKNOWN_ESCAPE = 4'd4,
        ST_SHORT_HEX      = 4'd5,
        ST_BAD_HEX        = 4'd6,
        ST_PAIR_CUT       = 4'd7,
        ST_EXPECTED_LOW   = 4'd8,
        ST_INVALID_LOW    = 4'd9,
        ST_LONE_LOW       = 4'd10
    } status_t;

    // Character codes the decoder reacts to.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // Surrogate ranges and the UTF-8 length limits.
    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [20:0] ONE_BYTE_MAX = 21'h7F;
    localparam logic [20:0] TWO_BYTE_MAX = 21'h7FF;
    localparam logic [20:0] THREE_BYTE_MAX = 21'hFFFF;

    localparam int RUN_MAX = 4;
    localparam int CNT_W   = $clog2(RUN_MAX + 1);

    // Up to four results caused by one request; bytes[0] goes out first.
    typedef struct packed {
        logic [CNT_W-1:0]          cnt;
        status_t                   status;
        logic [RUN_MAX-1:0][7:0]   bytes;
    } run_t;

    // Hex digit value in the low nibble; bit 4 set when not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b0, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Single-result run with the given status and byte.
    function automatic run_t one_run(input status_t st, input logic [7:0] b);
        run_t r;
        r = '0;
        r.cnt      = CNT_W'(1);
        r.status   = st;
        r.bytes[0] = b;
        return r;
    endfunction

    // UTF-8 encoding of a code point as a run of one to four bytes.
    function automatic run_t utf8_run(input logic [20:0] cp);
        run_t r;
        r = '0;
        r.status = ST_BYTE;
        if (cp <= ONE_BYTE_MAX) begin
            r.cnt      = CNT_W'(1);
            r.bytes[0] = cp[7:0];
        end else if (cp <= TWO_BYTE_MAX) begin
            r.cnt      = CNT_W'(2);
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= THREE_BYTE_MAX) begin
            r.cnt      = CNT_W'(3);
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.cnt      = CNT_W'(4);
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

@@ design/jsu_decode.sv @@
// Escape decoder: parse state registers and the single-pass decode of one
// request into a run of results. Depends on jsu_pkg.
module jsu_decode
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       commit,
    input  logic [7:0] in_byte,
    input  logic       in_ended,
    output run_t       run
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  digit_count_reg, digit_count_next;
    logic [11:0] hex_acc_reg, hex_acc_next;
    logic [9:0]  high_surr_reg, high_surr_next;

    logic [4:0]  digit;
    logic [15:0] hex_full;

    assign digit    = hex_value(in_byte);
    assign hex_full = {hex_acc_reg, digit[3:0]};

    // Decode of the current request against the parse state.
    always_comb begin
        phase_next       = phase_reg;
        digit_count_next = digit_count_reg;
        hex_acc_next     = hex_acc_reg;
        high_surr_next   = high_surr_reg;
        run              = '0;

        case (phase_reg)
            PH_ESCAPE: begin
                phase_next = PH_NORMAL;
                if (in_ended) begin
                    run = one_run(ST_ESCAPE_CUT, 8'h00);
                end else begin
                    case (in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: run = one_run(ST_BYTE, in_byte);
                        CH_LOW_B: run = one_run(ST_BYTE, 8'h08);
                        CH_LOW_F: run = one_run(ST_BYTE, 8'h0C);
                        CH_LOW_N: run = one_run(ST_BYTE, 8'h0A);
                        CH_LOW_R: run = one_run(ST_BYTE, 8'h0D);
                        CH_LOW_T: run = one_run(ST_BYTE, 8'h09);
                        CH_LOW_U: begin
                            phase_next       = PH_HEX_FIRST;
                            digit_count_next = 2'd0;
                            hex_acc_next     = 12'd0;
                        end
                        default: run = one_run(ST_UNKNOWN_ESCAPE, 8'h00);
                    endcase
                end
            end

            PH_HEX_FIRST, PH_HEX_LOW: begin
                if (in_ended || digit[4]) begin
                    // Any failure returns every state field to its reset value.
                    phase_next       = PH_NORMAL;
                    digit_count_next = 2'd0;
                    hex_acc_next     = 12'd0;
                    high_surr_next   = 10'd0;
                    run = one_run(in_ended ? ST_SHORT_HEX : ST_BAD_HEX, 8'h00);
                end else if (digit_count_reg != 2'd3) begin
                    digit_count_next = digit_count_reg + 2'd1;
                    hex_acc_next     = hex_full[11:0];
                end else begin
                    digit_count_next = 2'd0;
                    hex_acc_next     = 12'd0;
                    phase_next       = PH_NORMAL;
                    if (phase_reg == PH_HEX_FIRST) begin
                        if (hex_full inside {[HI_SURR_MIN:HI_SURR_MAX]}) begin
                            high_surr_next = hex_full[9:0];
                            phase_next     = PH_WANT_BSLASH;
                        end else if (hex_full inside {[LO_SURR_MIN:LO_SURR_MAX]}) begin
                            high_surr_next = 10'd0;
                            run = one_run(ST_LONE_LOW, 8'h00);
                        end else begin
                            high_surr_next = 10'd0;
                            run = utf8_run({5'd0, hex_full});
                        end
                    end else begin
                        high_surr_next = 10'd0;
                        if (hex_full inside {[LO_SURR_MIN:LO_SURR_MAX]}) begin
                            run = utf8_run(SUPP_BASE + 21'({high_surr_reg, hex_full[9:0]}));
                        end else begin
                            run = one_run(ST_INVALID_LOW, 8'h00);
                        end
                    end
                end
            end

            PH_WANT_BSLASH, PH_WANT_U: begin
                if (in_ended || in_byte != ((phase_reg == PH_WANT_BSLASH) ? CH_BSLASH
                                                                            : CH_LOW_U)) begin
                    phase_next       = PH_NORMAL;
                    digit_count_next = 2'd0;
                    hex_acc_next     = 12'd0;
                    high_surr_next   = 10'd0;
                    run = one_run(in_ended ? ST_PAIR_CUT : ST_EXPECTED_LOW, 8'h00);
                end else if (phase_reg == PH_WANT_BSLASH) begin
                    phase_next = PH_WANT_U;
                end else begin
                    phase_next       = PH_HEX_LOW;
                    digit_count_next = 2'd0;
                    hex_acc_next     = 12'd0;
                end
            end

            default: begin
                phase_next = PH_NORMAL;
                if (in_ended) begin
                    digit_count_next = 2'd0;
                    hex_acc_next     = 12'd0;
                    high_surr_next   = 10'd0;
                    run = one_run(ST_UNTERMINATED, 8'h00);
                end else if (in_byte == CH_QUOTE) begin
                    digit_count_next = 2'd0;
                    hex_acc_next     = 12'd0;
                    high_surr_next   = 10'd0;
                    run = one_run(ST_END, 8'h00);
                end else if (in_byte == CH_BSLASH) begin
                    phase_next = PH_ESCAPE;
                end else begin
                    run = one_run(ST_BYTE, in_byte);
                end
            end
        endcase
    end

    // Parse state advances only when the request is committed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_NORMAL;
            digit_count_reg <= 2'd0;
            hex_acc_reg     <= 12'd0;
            high_surr_reg   <= 10'd0;
        end else if (commit) begin
            phase_reg       <= phase_next;
            digit_count_reg <= digit_count_next;
            hex_acc_reg     <= hex_acc_next;
            high_surr_reg   <= high_surr_next;
        end
    end

endmodule

@@ design/jsu_out.sv @@
// Result register: holds one run of up to four results and hands them out
// one per cycle while m_ready is high. Depends on jsu_pkg.
module jsu_out
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  run_t       run,
    output logic       free,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [3:0] m_status,
    output logic       m_last_of_run
);

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    status_t                 status_reg;
    logic [RUN_MAX-1:0][7:0] bytes_reg;
    logic                    take;

    assign m_valid       = (cnt_reg != '0);
    assign m_out_byte    = bytes_reg[0];
    assign m_status      = status_reg;
    assign m_last_of_run = (cnt_reg == CNT_W'(1));
    assign take          = m_valid && m_ready;

    // The register can take a new run when empty or when its last result leaves.
    assign free = !m_valid || (take && m_last_of_run);

    always_comb begin
        cnt_next = cnt_reg;
        if (advance) begin
            cnt_next = run.cnt;
        end else if (take) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload: load a fresh run, or shift the next byte into place.
    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg <= run.status;
            bytes_reg  <= run.bytes;
        end else if (take) begin
            bytes_reg  <= bytes_reg >> 8;
        end
    end

endmodule

@@ design/json_string_unescape_utf8.sv @@
// Top level of the JSON string unescaper: input register, decoder and
// result register. Depends on jsu_pkg, jsu_decode, jsu_out, assert_macros.svh.
//
// Usage: feed the bytes of a JSON string body, after the opening quote, on
// s_in_byte one request per s_valid/s_ready handshake; set s_source_ended to
// mark that the source has no more bytes. Each request gives zero to four
// results on m_out_byte/m_status/m_last_of_run, the last of them flagged by
// m_last_of_run. Status 0 carries a decoded byte, 1 the closing quote, and
// 2 to 10 an error; after an end or an error the decoder is back in its start
// state. A request passes the input and result registers in turn. The block
// takes one request per cycle while each gives at most one result; a request
// that gives an n-byte UTF-8 sequence holds the result register until its bytes
// have left, and the input side waits. When the receiver stalls, results hold
// in the result register and the input register fills, then s_ready drops.
// Reset (aresetn, synchronous, active low) empties both registers and returns
// the decoder to its normal character phase.
`include "assert_macros.svh"

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_source_ended,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [3:0] m_status,
    output logic       m_last_of_run
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_ended_reg;
    logic       out_free;
    logic       advance;
    run_t       run;

    // A held request moves on once the result register can take its run.
    assign advance = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_in_byte;
            in_ended_reg <= s_source_ended;
        end
    end

    jsu_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .commit   (advance),
        .in_byte  (in_byte_reg),
        .in_ended (in_ended_reg),
        .run      (run)
    );

    jsu_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .run           (run),
        .free          (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run)
    );

    // Only decoded bytes come in multi-result runs.
    `JSU_ASSERT_IMP(a_status_single, aclk, aresetn, m_valid && m_status != ST_BYTE, m_last_of_run)
    // Taking a result that is not the last keeps the run on the output.
    `JSU_ASSERT_NEXT(a_run_continues, aclk, aresetn, m_valid && m_ready && !m_last_of_run, m_valid)
    // A stalled request stays in the input register unchanged.
    `JSU_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance,
                     in_valid_reg && $stable(in_byte_reg) && $stable(in_ended_reg))

endmodule
